FILE: design/votp_pkg.sv
// ----------------------------------------------------------------------------
// votp_pkg
// Types and codes shared by the vendor option TLV parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package votp_pkg;

	localparam logic [1:0] ROLE_CODE    = 2'd0;
	localparam logic [1:0] ROLE_LENGTH  = 2'd1;
	localparam logic [1:0] ROLE_PAYLOAD = 2'd2;
	localparam logic [1:0] ROLE_SKIP    = 2'd3;

	localparam logic [1:0] KIND_ENDPOINT    = 2'd0;
	localparam logic [1:0] KIND_FINGERPRINT = 2'd1;
	localparam logic [1:0] KIND_DIGEST_TYPE = 2'd2;
	localparam logic [1:0] KIND_NONE        = 2'd3;

	localparam logic [1:0] VERDICT_PENDING  = 2'd0;
	localparam logic [1:0] VERDICT_ACCEPTED = 2'd1;
	localparam logic [1:0] VERDICT_REJECTED = 2'd2;

	localparam logic [1:0] REG_ENDPOINT_CODE    = 2'd0;
	localparam logic [1:0] REG_FINGERPRINT_CODE = 2'd1;
	localparam logic [1:0] REG_DIGEST_TYPE_CODE = 2'd2;

	localparam logic [7:0] ENDPOINT_CODE_RESET    = 8'd200;
	localparam logic [7:0] FINGERPRINT_CODE_RESET = 8'd201;
	localparam logic [7:0] DIGEST_TYPE_CODE_RESET = 8'd202;

	localparam int unsigned PADDR_W = 4;

	typedef struct packed {
		logic [7:0] endpoint_code;
		logic [7:0] fingerprint_code;
		logic [7:0] digest_type_code;
	} cfg_t;

	typedef struct packed {
		logic [1:0] role;
		logic [1:0] option_kind;
		logic [7:0] payload_offset;
		logic [7:0] payload_value;
		logic       payload_end;
		logic [1:0] verdict;
		logic       done_res;
	} result_t;

endpackage

`default_nettype wire

FILE: design/votp_byte_if.sv
// ----------------------------------------------------------------------------
// votp_byte_if
// Valid/ready channel that carries one byte of the option buffer.
// ----------------------------------------------------------------------------
`default_nettype none

interface votp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

`default_nettype wire

FILE: design/votp_result_if.sv
// ----------------------------------------------------------------------------
// votp_result_if
// Valid/ready channel that carries the tag of one parsed byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface votp_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] role;
	logic [1:0] option_kind;
	logic [7:0] payload_offset;
	logic [7:0] payload_value;
	logic       payload_end;
	logic [1:0] verdict;
	logic       done_res;

	modport source (output valid, output role, output option_kind, output payload_offset,
		output payload_value, output payload_end, output verdict, output done_res,
		input ready);
	modport sink (input valid, input role, input option_kind, input payload_offset,
		input payload_value, input payload_end, input verdict, input done_res,
		output ready);
endinterface

`default_nettype wire

FILE: design/votp_walker.sv
// ----------------------------------------------------------------------------
// votp_walker
// Walk state of the TLV parser and the tagging of one byte per enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module votp_walker
	import votp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire logic [7:0] data_byte,
	input  wire logic       final_byte,
	input  wire cfg_t       cfg,
	output result_t         result
);

	typedef enum logic [1:0] {
		PH_CODE    = 2'd0,
		PH_LENGTH  = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_SKIP    = 2'd3
	} phase_t;

	phase_t     phase_q, phase_n;
	logic [7:0] bytes_left_q, bytes_left_n;
	logic [1:0] current_option_q, current_option_n;
	logic [7:0] pending_code_q, pending_code_n;
	logic [7:0] offset_count_q, offset_count_n;
	logic       failed_q, failed_n;
	logic [1:0] match_kind;

	// Priority match of the held code against the configured codes.
	always_comb begin
		if (pending_code_q == cfg.endpoint_code) begin
			match_kind = KIND_ENDPOINT;
		end else if (pending_code_q == cfg.fingerprint_code) begin
			match_kind = KIND_FINGERPRINT;
		end else if (pending_code_q == cfg.digest_type_code) begin
			match_kind = KIND_DIGEST_TYPE;
		end else begin
			match_kind = KIND_NONE;
		end
	end

	always_comb begin
		phase_n          = phase_q;
		bytes_left_n     = bytes_left_q;
		current_option_n = current_option_q;
		pending_code_n   = pending_code_q;
		offset_count_n   = offset_count_q;
		failed_n         = failed_q;

		result.role           = ROLE_SKIP;
		result.option_kind    = KIND_NONE;
		result.payload_offset = 8'd0;
		result.payload_value  = data_byte;
		result.payload_end    = 1'b0;
		result.verdict        = VERDICT_PENDING;
		result.done_res       = final_byte;

		case (phase_q)
			PH_CODE: begin
				// A code byte that is also the last byte is ignored.
				if (!final_byte) begin
					result.role    = ROLE_CODE;
					pending_code_n = data_byte;
					phase_n        = PH_LENGTH;
				end
			end
			PH_LENGTH: begin
				result.role        = ROLE_LENGTH;
				result.option_kind = match_kind;
				current_option_n   = match_kind;
				if (data_byte == 8'd0 || match_kind == KIND_NONE || final_byte) begin
					failed_n = 1'b1;
					phase_n  = PH_SKIP;
				end else begin
					bytes_left_n   = data_byte;
					offset_count_n = 8'd0;
					phase_n        = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				result.role           = ROLE_PAYLOAD;
				result.option_kind    = current_option_q;
				result.payload_offset = offset_count_q;
				offset_count_n        = offset_count_q + 8'd1;
				if (bytes_left_q <= 8'd1) begin
					result.payload_end = 1'b1;
					bytes_left_n       = 8'd0;
					current_option_n   = KIND_NONE;
					phase_n            = PH_CODE;
				end else begin
					bytes_left_n = bytes_left_q - 8'd1;
					// The buffer ends while payload is still owed.
					if (final_byte) begin
						failed_n = 1'b1;
						phase_n  = PH_SKIP;
					end
				end
			end
			default: begin
			end
		endcase

		if (final_byte) begin
			result.verdict   = failed_n ? VERDICT_REJECTED : VERDICT_ACCEPTED;
			phase_n          = PH_CODE;
			bytes_left_n     = 8'd0;
			current_option_n = KIND_NONE;
			pending_code_n   = 8'd0;
			offset_count_n   = 8'd0;
			failed_n         = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_CODE;
			bytes_left_q     <= 8'd0;
			current_option_q <= KIND_NONE;
			pending_code_q   <= 8'd0;
			offset_count_q   <= 8'd0;
			failed_q         <= 1'b0;
		end else if (en) begin
			phase_q          <= phase_n;
			bytes_left_q     <= bytes_left_n;
			current_option_q <= current_option_n;
			pending_code_q   <= pending_code_n;
			offset_count_q   <= offset_count_n;
			failed_q         <= failed_n;
		end
	end

endmodule

`default_nettype wire

FILE: design/vendor_option_tlv_parser_top.sv
// ----------------------------------------------------------------------------
// vendor_option_tlv_parser_top
// Tags each byte of a vendor option buffer and reports a verdict per buffer.
// ----------------------------------------------------------------------------
// Bytes of an option buffer enter on the bytes channel, with final_byte set
// on the last byte of each buffer. For every byte one tag leaves on the
// results channel: its role, the option it belongs to, its payload offset,
// the byte itself, an end-of-payload flag, and on the last byte the verdict.
// Each transaction is captured in an input register and tagged by the walk
// logic on the way into the output register, and one byte is taken every
// cycle while the skid buffer is free. A one-entry skid buffer behind the
// output register lets the input keep accepting while a tag waits; when the
// receiver stalls, at most three bytes are held inside the block before
// ready drops. The three option codes are written over the APB port (byte
// addresses 0, 4 and 8); they must be changed by the user only between
// buffers, which the block does not enforce. Reset returns the codes to 200,
// 201 and 202, empties all stages and puts the walk at a code byte.
// ----------------------------------------------------------------------------
`default_nettype none

module vendor_option_tlv_parser_top
	import votp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	votp_byte_if.sink               bytes,
	votp_result_if.source           results
);

	cfg_t       cfg_q;
	logic [1:0] reg_index;
	logic       cfg_write;

	logic       valid_s1;
	logic [7:0] data_byte_s1;
	logic       final_byte_s1;
	logic       advance;

	result_t    tag;
	result_t    out_q;
	logic       out_valid_q;
	result_t    skid_q;
	logic       skid_valid_q;

	assign pready    = 1'b1;
	assign reg_index = paddr[3:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.endpoint_code    <= ENDPOINT_CODE_RESET;
			cfg_q.fingerprint_code <= FINGERPRINT_CODE_RESET;
			cfg_q.digest_type_code <= DIGEST_TYPE_CODE_RESET;
		end else if (cfg_write) begin
			case (reg_index)
				REG_ENDPOINT_CODE:    cfg_q.endpoint_code    <= pwdata[7:0];
				REG_FINGERPRINT_CODE: cfg_q.fingerprint_code <= pwdata[7:0];
				REG_DIGEST_TYPE_CODE: cfg_q.digest_type_code <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_index)
			REG_ENDPOINT_CODE:    prdata = {24'd0, cfg_q.endpoint_code};
			REG_FINGERPRINT_CODE: prdata = {24'd0, cfg_q.fingerprint_code};
			REG_DIGEST_TYPE_CODE: prdata = {24'd0, cfg_q.digest_type_code};
			default:              prdata = 32'd0;
		endcase
	end

	// The input stage moves on whenever the skid buffer is free.
	assign advance     = valid_s1 && !skid_valid_q;
	assign bytes.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			data_byte_s1  <= bytes.data_byte;
			final_byte_s1 <= bytes.final_byte;
		end
	end

	votp_walker u_walker (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.data_byte  (data_byte_s1),
		.final_byte (final_byte_s1),
		.cfg        (cfg_q),
		.result     (tag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				if (out_valid_q && !results.ready) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (out_valid_q && results.ready) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (out_valid_q && !results.ready) begin
				skid_q <= tag;
			end else begin
				out_q <= tag;
			end
		end else if (out_valid_q && results.ready && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.role           = out_q.role;
	assign results.option_kind    = out_q.option_kind;
	assign results.payload_offset = out_q.payload_offset;
	assign results.payload_value  = out_q.payload_value;
	assign results.payload_end    = out_q.payload_end;
	assign results.verdict        = out_q.verdict;
	assign results.done_res       = out_q.done_res;

endmodule

`default_nettype wire
